>>> hdl/tte_pkg.sv
package tte_pkg;

	// history ring
	localparam int HISTORY_DEPTH = 8;
	localparam int TIME_W        = 40;
	localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

	// interval sum and divider
	localparam int SUM_W  = TIME_W + ADDR_W;
	localparam int NUM_W  = SUM_W + 1;
	localparam int QUO_W  = 20;
	localparam int DSH_W  = SUM_W + QUO_W;
	localparam int QCNT_W = $clog2(QUO_W);

	// twice the ms-to-BPM scale, tenths and whole
	localparam int SCALE_TENTHS_X2 = 1200000;
	localparam int SCALE_WHOLE_X2  = 120000;

	// field and register widths
	localparam int TIMEOUT_W = 16;
	localparam int BPM_W     = 10;
	localparam int TENTHS_W  = 14;
	localparam int TAPS_W    = 4;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(2000);
	localparam logic [BPM_W-1:0]     MIN_BPM_RST = BPM_W'(30);
	localparam logic [BPM_W-1:0]     MAX_BPM_RST = BPM_W'(300);

	localparam logic REQ_TAP   = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		REG_TIMEOUT = 2'd0,
		REG_MIN_BPM = 2'd1,
		REG_MAX_BPM = 2'd2
	} reg_idx_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PREV  = 7'b0000010,
		ST_WALK  = 7'b0000100,
		ST_PREP  = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_CLAMP = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic              req_type;
		logic [TIME_W-1:0] tap_time_ms;
	} req_t;

	typedef struct packed {
		logic [TENTHS_W-1:0] bpm_tenths;
		logic [BPM_W-1:0]    tempo_whole;
		logic [TAPS_W-1:0]   taps_held;
	} rsp_t;

endpackage

>>> hdl/tte_ram.sv
module tte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/tap_tempo_estimator.sv
// Tap tempo estimator. Each request on the req channel either records a tap
// (req_type 0, with a millisecond timestamp) or clears the tap history
// (req_type 1); every request yields exactly one result on the rsp channel.
// The last HISTORY_DEPTH timestamps live in a one-port-write, one-port-read
// RAM. A tap more than timeout_ms after the previous stored tap restarts the
// history. The positive gaps between consecutive stored taps are summed and
// counted, and the tempo 60000*count/sum is given in tenths and whole BPM,
// rounded half up and clamped to min_bpm first and max_bpm second (max wins).
// Both tempo fields are 0 with fewer than two taps or no positive gap.
// Sequence: a clear goes straight to its result. A tap first reads the
// previous tap from the RAM. With two or more taps held, the interval walk
// reads each stored tap but the newest, which is still in now_q, and then a
// 20-step shift-subtract divider works out both tempo quotients at once,
// followed by the clamp. Without a positive gap the divider is skipped, and
// a lone tap skips the walk as well.
// The result sits in an output register, so a new request is taken while a
// finished result still waits for rsp_stall to drop. Registers (APB, 32-bit):
// 0x0 timeout_ms, 0x4 min_bpm, 0x8 max_bpm; write them only while idle.
module tap_tempo_estimator
	import tte_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,

	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// ---------------------------------------------------------------- config
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [BPM_W-1:0]     min_bpm_q;
	logic [BPM_W-1:0]     max_bpm_q;
	logic                 cfg_wr;
	reg_idx_t             cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_comb begin
		case (cfg_idx)
			REG_TIMEOUT: prdata = PDATA_W'(timeout_q);
			REG_MIN_BPM: prdata = PDATA_W'(min_bpm_q);
			REG_MAX_BPM: prdata = PDATA_W'(max_bpm_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			min_bpm_q <= MIN_BPM_RST;
			max_bpm_q <= MAX_BPM_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TIMEOUT: timeout_q <= pwdata[TIMEOUT_W-1:0];
				REG_MIN_BPM: min_bpm_q <= pwdata[BPM_W-1:0];
				REG_MAX_BPM: max_bpm_q <= pwdata[BPM_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ registers
	state_t              state_q;
	logic [CNT_W-1:0]    valid_q;      // taps held
	logic [ADDR_W-1:0]   slot_q;       // next slot to write
	logic [CNT_W-1:0]    rd_idx_q;     // walk reads issued
	logic                rd_vld_s1;    // RAM data of a walk read is present
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [TIME_W-1:0]   now_q;
	logic [ADDR_W-1:0]   rd_addr_q;
	logic                first_q;
	logic [TIME_W-1:0]   a_q;          // previous element of the walk
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    n_q;
	logic [NUM_W-1:0]    rem10_q;
	logic [NUM_W-1:0]    rem1_q;
	logic [QUO_W-1:0]    q10_q;
	logic [QUO_W-1:0]    q1_q;
	logic [DSH_W-1:0]    dsh_q;        // 2*sum, shifted to the current quotient bit
	logic [QCNT_W-1:0]   qcnt_q;
	rsp_t                pend_q;       // finished result awaiting the output register

	// ------------------------------------------------------------------ RAM
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [TIME_W-1:0]   ram_rdata;
	logic [ADDR_W-1:0]   last_addr;

	tte_ram #(
		.WIDTH (TIME_W),
		.DEPTH (HISTORY_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (now_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign last_addr = (slot_q == '0) ? ADDR_W'(HISTORY_DEPTH - 1) : slot_q - 1'b1;
	assign ram_raddr = (state_q == ST_IDLE) ? last_addr : rd_addr_q;

	// ------------------------------------------------- previous-tap decision
	logic [TIME_W-1:0]   gap;
	logic                timed_out;
	logic [CNT_W-1:0]    base_cnt;
	logic [CNT_W-1:0]    v_new;
	logic [ADDR_W-1:0]   slot_new;
	logic [ADDR_W:0]     old_sum;
	logic [ADDR_W:0]     old_wrap;
	logic [ADDR_W-1:0]   oldest;

	always_comb begin
		gap       = now_q - ram_rdata;
		timed_out = (valid_q != '0) && (now_q >= ram_rdata) &&
		            (gap > TIME_W'(timeout_q));
		base_cnt  = timed_out ? '0 : valid_q;
		ram_waddr = timed_out ? '0 : slot_q;
		ram_we    = (state_q == ST_PREV);
		v_new     = (base_cnt < CNT_W'(HISTORY_DEPTH)) ? base_cnt + 1'b1 : base_cnt;
		slot_new  = (ram_waddr == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : ram_waddr + 1'b1;
		old_sum   = (ADDR_W + 1)'(slot_new) + (ADDR_W + 1)'(HISTORY_DEPTH) -
		            (ADDR_W + 1)'(v_new);
		old_wrap  = (old_sum >= (ADDR_W + 1)'(HISTORY_DEPTH)) ?
		            old_sum - (ADDR_W + 1)'(HISTORY_DEPTH) : old_sum;
		oldest    = old_wrap[ADDR_W-1:0];
	end

	// ------------------------------------------------------- interval walk
	logic                rd_issue;
	logic                inject;
	logic                walk_proc;
	logic [TIME_W-1:0]   elem;

	always_comb begin
		rd_issue  = (state_q == ST_WALK) && (rd_idx_q < valid_q - 1'b1);
		// newest tap is still in now_q, so it closes the walk without a read
		inject    = (state_q == ST_WALK) && !rd_issue && !rd_vld_s1;
		walk_proc = rd_vld_s1 || inject;
		elem      = rd_vld_s1 ? ram_rdata : now_q;
	end

	// ------------------------------------------------------------- divider
	logic                ge10;
	logic                ge1;

	assign ge10 = DSH_W'(rem10_q) >= dsh_q;
	assign ge1  = DSH_W'(rem1_q) >= dsh_q;

	// --------------------------------------------------------------- clamp
	logic [QUO_W-1:0]    lo10;
	logic [QUO_W-1:0]    hi10;
	logic [QUO_W-1:0]    lo1;
	logic [QUO_W-1:0]    hi1;
	logic [QUO_W-1:0]    c10a;
	logic [QUO_W-1:0]    c10;
	logic [QUO_W-1:0]    c1a;
	logic [QUO_W-1:0]    c1;

	always_comb begin
		lo10 = QUO_W'(min_bpm_q) * QUO_W'(10);
		hi10 = QUO_W'(max_bpm_q) * QUO_W'(10);
		lo1  = QUO_W'(min_bpm_q);
		hi1  = QUO_W'(max_bpm_q);
		c10a = (q10_q < lo10) ? lo10 : q10_q;
		c10  = (c10a > hi10) ? hi10 : c10a;
		c1a  = (q1_q < lo1) ? lo1 : q1_q;
		c1   = (c1a > hi1) ? hi1 : c1a;
	end

	function automatic logic [TAPS_W-1:0] taps_of(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+TAPS_W-1:0] ext;
		ext = (CNT_W + TAPS_W)'(cnt);
		return ext[TAPS_W-1:0];
	endfunction

	// ------------------------------------------------------------- control
	logic req_take;
	logic rsp_load;

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			slot_q      <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one taken at this same edge
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			rd_vld_s1 <= rd_issue;
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						if (req.req_type == REQ_CLEAR) begin
							valid_q <= '0;
							slot_q  <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_PREV;
						end
					end
				end
				ST_PREV: begin
					valid_q  <= v_new;
					slot_q   <= slot_new;
					rd_idx_q <= '0;
					state_q  <= (v_new < CNT_W'(2)) ? ST_DONE : ST_WALK;
				end
				ST_WALK: begin
					if (rd_issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (inject) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= (n_q == '0) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (qcnt_q == '0) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------ datapath
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= pend_q;
		end
		case (state_q)
			ST_IDLE: begin
				now_q  <= req.tap_time_ms;
				pend_q <= '0;
			end
			ST_PREV: begin
				rd_addr_q <= oldest;
				first_q   <= 1'b1;
				sum_q     <= '0;
				n_q       <= '0;
				pend_q    <= '{bpm_tenths: '0, tempo_whole: '0, taps_held: taps_of(v_new)};
			end
			ST_WALK: begin
				if (rd_issue) begin
					rd_addr_q <= (rd_addr_q == ADDR_W'(HISTORY_DEPTH - 1)) ?
					             '0 : rd_addr_q + 1'b1;
				end
				if (walk_proc) begin
					first_q <= 1'b0;
					a_q     <= elem;
					if (!first_q && (elem > a_q)) begin
						sum_q <= sum_q + SUM_W'(elem - a_q);
						n_q   <= n_q + 1'b1;
					end
				end
			end
			ST_PREP: begin
				// numerators 2*scale*n + sum; divisor 2*sum aligned to the top bit
				rem10_q <= NUM_W'(SCALE_TENTHS_X2) * NUM_W'(n_q) + NUM_W'(sum_q);
				rem1_q  <= NUM_W'(SCALE_WHOLE_X2) * NUM_W'(n_q) + NUM_W'(sum_q);
				dsh_q   <= {sum_q, {QUO_W{1'b0}}};
				qcnt_q  <= QCNT_W'(QUO_W - 1);
				q10_q   <= '0;
				q1_q    <= '0;
			end
			ST_DIV: begin
				if (ge10) begin
					rem10_q <= rem10_q - dsh_q[NUM_W-1:0];
				end
				if (ge1) begin
					rem1_q <= rem1_q - dsh_q[NUM_W-1:0];
				end
				q10_q  <= {q10_q[QUO_W-2:0], ge10};
				q1_q   <= {q1_q[QUO_W-2:0], ge1};
				dsh_q  <= dsh_q >> 1;
				qcnt_q <= qcnt_q - 1'b1;
			end
			ST_CLAMP: begin
				pend_q <= '{bpm_tenths: c10[TENTHS_W-1:0], tempo_whole: c1[BPM_W-1:0],
				           taps_held: pend_q.taps_held};
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
